// File: rtl/core/pfcu_pkg.sv
// ----------------------------------------------------------------------------
// pfcu_pkg: shared types and constants for the phase-field cell update
// Grid geometry, field widths, register indexes and controller interface.
// ----------------------------------------------------------------------------
package pfcu_pkg;

  localparam int GridSide  = 16;
  localparam int MaxGrains = 8;
  localparam int CoordW    = 4;
  localparam int GrainW    = 3;
  localparam int AddrW     = GrainW + 3 * CoordW;
  localparam int ValW      = 18;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 32;

  localparam logic [CfgAddrW-1:0] RegCoefA   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegCoefB   = 3'd1;
  localparam logic [CfgAddrW-1:0] RegDfRate  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegLapX    = 3'd3;
  localparam logic [CfgAddrW-1:0] RegLapY    = 3'd4;
  localparam logic [CfgAddrW-1:0] RegLapZ    = 3'd5;
  localparam logic [CfgAddrW-1:0] RegActive  = 3'd6;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  // Read slots: 0 center, 1..6 neighbors (x-,x+,y-,y+,z-,z+), 7..14 grains.
  localparam int SlotW = 4;

  typedef struct packed {
    logic             load;     // capture accepted input item
    logic             wr;       // store write_value
    logic             rd;       // issue read for slot
    logic [SlotW-1:0] slot;
    logic             cap;      // capture read data for slot cap_slot
    logic [SlotW-1:0] cap_slot;
    logic [3:0]       step;     // arithmetic step
    logic             calc;
  } pfcu_cmd_t;

endpackage

// File: rtl/core/pfcu_ctrl.sv
// ----------------------------------------------------------------------------
// pfcu_ctrl: sequencer for the phase-field cell update
// Handles write items in idle; for an update steps through reads of the memory,
// then the arithmetic steps, then output.
module pfcu_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_cmd,
  input  logic                 out_busy,
  output logic                 out_load,
  output pfcu_pkg::pfcu_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic [pfcu_pkg::SlotW-1:0] LastSlot = 4'd14;
  localparam logic [3:0] LastStep = 4'd7;

  state_t state_r, state_nxt;
  logic [pfcu_pkg::SlotW-1:0] slot_r, slot_nxt;
  logic                       cap_r;
  logic [pfcu_pkg::SlotW-1:0] cap_slot_r;
  logic [3:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    cmd       = '0;
    cmd.cap      = cap_r;
    cmd.cap_slot = cap_slot_r;
    cmd.step     = step_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_cmd == pfcu_pkg::CmdWrite) begin
            cmd.wr = 1'b1;
          end else begin
            slot_nxt  = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd   = 1'b1;
        cmd.slot = slot_r;
        if (slot_r == LastSlot) begin
          step_nxt  = '0;
          state_nxt = ST_CALC;
        end else begin
          slot_nxt = slot_r + 4'd1;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (step_r == LastStep) state_nxt = ST_DONE;
        else step_nxt = step_r + 4'd1;
      end
      ST_DONE: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cap_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cap_r   <= cmd.rd;
    end
    slot_r     <= slot_nxt;
    step_r     <= step_nxt;
    cap_slot_r <= cmd.slot;
  end

endmodule

// File: rtl/core/pfcu_datapath.sv
// ----------------------------------------------------------------------------
// pfcu_datapath: field memory and arithmetic for the cell update
// One memory read per cycle; at most two multiplies per arithmetic step.
// ----------------------------------------------------------------------------
module pfcu_datapath (
  input  logic                       clk,
  input  pfcu_pkg::pfcu_cmd_t        cmd,
  input  logic [2:0]                 in_grain,
  input  logic [3:0]                 in_x,
  input  logic [3:0]                 in_y,
  input  logic [3:0]                 in_z,
  input  logic signed [17:0]         in_value,
  input  logic [17:0]                coef_a,
  input  logic [17:0]                coef_b,
  input  logic [31:0]                df_rate,
  input  logic [15:0]                lap_x,
  input  logic [15:0]                lap_y,
  input  logic [15:0]                lap_z,
  input  logic [3:0]                 active,
  output logic signed [17:0]         res_value,
  output logic                       res_sat
);

  localparam int Depth = pfcu_pkg::MaxGrains * pfcu_pkg::GridSide ** 3;

  logic signed [17:0] mem [Depth];
  logic signed [17:0] rdata_r;
  logic               rvalid_r, rvalid_nxt;

  logic [2:0] g_r;
  logic [3:0] x_r, y_r, z_r;

  logic signed [17:0] e_r, nb_r [6];
  logic signed [39:0] sum_r;
  logic signed [47:0] e2_r, e3_r;
  logic signed [79:0] drive_r;
  logic signed [49:0] lap_r;
  logic signed [31:0] drv14_r;
  logic signed [67:0] stp_r;
  logic signed [31:0] res_r;

  // Read address for each slot, with an in-range flag.
  logic [2:0] ag;
  logic [4:0] ax, ay, az;
  logic       aok;

  always_comb begin
    ag = g_r;
    ax = {1'b0, x_r};
    ay = {1'b0, y_r};
    az = {1'b0, z_r};
    case (cmd.slot)
      4'd1: ax = {1'b0, x_r} - 5'd1;
      4'd2: ax = {1'b0, x_r} + 5'd1;
      4'd3: ay = {1'b0, y_r} - 5'd1;
      4'd4: ay = {1'b0, y_r} + 5'd1;
      4'd5: az = {1'b0, z_r} - 5'd1;
      4'd6: az = {1'b0, z_r} + 5'd1;
      default: ;
    endcase
    if (cmd.slot >= 4'd7) ag = 3'(cmd.slot - 4'd7);
    aok = !ax[4] && !ay[4] && !az[4] &&
          (cmd.slot < 4'd7 || {1'b0, cmd.slot - 4'd7} < {1'b0, active});
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) mem[{in_grain, in_x, in_y, in_z}] <= in_value;
    rdata_r <= mem[{ag, ax[3:0], ay[3:0], az[3:0]}];
    rvalid_r <= rvalid_nxt;
  end

  assign rvalid_nxt = aok;

  function automatic logic signed [79:0] rnd(input logic signed [79:0] v,
                                             input int s);
    logic signed [79:0] t;
    t = v + (80'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  logic signed [17:0] rd_v;
  assign rd_v = rvalid_r ? rdata_r : 18'sd0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_r <= in_grain; x_r <= in_x; y_r <= in_y; z_r <= in_z;
      sum_r <= '0;
    end
    if (cmd.cap) begin
      if (cmd.cap_slot == 4'd0) e_r <= rd_v;
      else if (cmd.cap_slot <= 4'd6) nb_r[3'(cmd.cap_slot - 4'd1)] <= rd_v;
      else sum_r <= sum_r + 40'(rd_v) * 40'(rd_v);
    end
    if (cmd.calc) begin
      case (cmd.step)
        4'd0: e2_r <= 48'(e_r) * 48'(e_r);
        4'd1: e3_r <= 48'(rnd(80'(e2_r) * 80'(e_r), 14));
        4'd2: drive_r <= -80'(80'($signed({1'b0, coef_a})) * e_r) * 80'sd16384;
        4'd3: drive_r <= drive_r + 80'($signed({1'b0, coef_b})) * 80'(e3_r);
        4'd4: drive_r <= drive_r + 80'(80'sd2 * e_r * (48'(sum_r) - e2_r));
        4'd5: begin
          drv14_r <= 32'(rnd(drive_r, 28));
          lap_r <= 50'(20'(nb_r[0]) + 20'(nb_r[1]) - 20'(e_r) * 20'sd2)
                   * 50'($signed({1'b0, lap_x}));
        end
        4'd6: begin
          stp_r <= 68'(drv14_r) * 68'($signed({1'b0, df_rate}));
          lap_r <= lap_r + 50'(20'(nb_r[2]) + 20'(nb_r[3]) - 20'(e_r) * 20'sd2)
                           * 50'($signed({1'b0, lap_y}));
        end
        4'd7: res_r <= 32'(e_r) - 32'(rnd(80'(stp_r), 32)) +
                       32'(rnd(80'(lap_r + 50'(20'(nb_r[4]) + 20'(nb_r[5])
                            - 20'(e_r) * 20'sd2) * 50'($signed({1'b0, lap_z}))), 16));
        default: ;
      endcase
    end
  end

  always_comb begin
    res_sat   = 1'b0;
    res_value = 18'(res_r);
    if (res_r > 32'sd131071) begin
      res_value = 18'sd131071; res_sat = 1'b1;
    end else if (res_r < -32'sd131072) begin
      res_value = -18'sd131072; res_sat = 1'b1;
    end
  end

endmodule

// File: rtl/core/phase_field_cell_update.sv
// ----------------------------------------------------------------------------
// phase_field_cell_update: multiphase-field grain cell update
// Usage: the in_ stream carries write and update items. A write stores one
// Q4.14 value of one grain at one cell and gives no result. An update reads
// the cell, its six neighbors and every active grain at the cell (one memory
// read a cycle, 15 reads), runs eight arithmetic steps of at most two
// multiplies each, and sends one result on the out_ stream.
// A write is stored as it is taken. An update's result is loaded into the output
// register after its reads, its arithmetic steps and the output load state; the
// next item is taken once the block is back in its idle state.
// Items are handled one at a time.
// The result sits in an output register; the next item is taken while it
// waits, and a stalled receiver holds the block only when a second result is
// ready. Reset restores the register defaults; the field memory is undefined
// until written. Configuration must be written via cfg_ while idle; not enforced.
// ----------------------------------------------------------------------------
module phase_field_cell_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: command, grain[3], cell_x[4], cell_y[4], cell_z[4], write_value[18], pad
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: new_value[18], saturated, pad
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  logic [17:0] coef_a_r, coef_b_r;
  logic [31:0] df_rate_r;
  logic [15:0] lap_x_r, lap_y_r, lap_z_r;
  logic [3:0]  active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= 18'd16384; coef_b_r <= 18'd16384; df_rate_r <= '0;
      lap_x_r <= 16'd4745; lap_y_r <= 16'd4745; lap_z_r <= 16'd4745;
      active_r <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        pfcu_pkg::RegCoefA:  coef_a_r  <= cfg_wdata[17:0];
        pfcu_pkg::RegCoefB:  coef_b_r  <= cfg_wdata[17:0];
        pfcu_pkg::RegDfRate: df_rate_r <= cfg_wdata;
        pfcu_pkg::RegLapX:   lap_x_r   <= cfg_wdata[15:0];
        pfcu_pkg::RegLapY:   lap_y_r   <= cfg_wdata[15:0];
        pfcu_pkg::RegLapZ:   lap_z_r   <= cfg_wdata[15:0];
        pfcu_pkg::RegActive: active_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  pfcu_pkg::pfcu_cmd_t cmd;
  logic        out_load;
  logic signed [17:0] res_value;
  logic        res_sat;
  logic        out_valid_r;
  logic [18:0] out_data_r;

  pfcu_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_cmd(in_tdata[0]),
    .out_busy(out_valid_r && !out_tready),
    .out_load, .cmd
  );

  pfcu_datapath u_dp (
    .clk, .cmd,
    .in_grain(in_tdata[3:1]), .in_x(in_tdata[7:4]), .in_y(in_tdata[11:8]),
    .in_z(in_tdata[15:12]), .in_value(in_tdata[33:16]),
    .coef_a(coef_a_r), .coef_b(coef_b_r), .df_rate(df_rate_r),
    .lap_x(lap_x_r), .lap_y(lap_y_r), .lap_z(lap_z_r),
    .active(active_r > 4'd8 ? 4'd8 : active_r),
    .res_value, .res_sat
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (out_load) out_data_r <= {res_sat, res_value};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

endmodule
